// ----- sv/shab_pkg.sv -----
// Shared types, constants and the round-constant table of the SHA-256 byte-stream hasher.
package shab_pkg;

  typedef logic [31:0] shab_word_t;

  // Eight hash words, element 0 is word A (most significant digest word).
  typedef shab_word_t [0:7] shab_hash_t;

  // Write request from the byte packer / padder into the block memory.
  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    shab_word_t data;
  } shab_wr_t;

  localparam shab_hash_t ShabIv = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [3:0] LenHiAddr = 4'd14;
  localparam logic [3:0] LenLoAddr = 4'd15;

  function automatic shab_word_t round_k(input logic [5:0] idx);
    shab_word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// ----- sv/shab_compress.sv -----
// Block memory with in-place message schedule expansion and the 64-round compression unit.
module shab_compress import shab_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  shab_wr_t   wr_i,
  input  logic       start_i,
  input  shab_hash_t hash_i,
  output logic       done_o,
  output shab_hash_t hash_o
);

  localparam logic [1:0] PH_RD_LO = 2'd0;
  localparam logic [1:0] PH_RD_HI = 2'd1;
  localparam logic [1:0] PH_EXP   = 2'd2;
  localparam logic [1:0] PH_RND   = 2'd3;

  function automatic shab_word_t ror(input shab_word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  shab_word_t mem [16];
  shab_word_t rd_a_q, rd_b_q;
  logic [3:0] rd_a_addr, rd_b_addr;

  logic       busy_q, done_q;
  logic [5:0] rnd_q;
  logic [1:0] phase_q;
  shab_hash_t v_q, v_next;
  shab_word_t w16_q, w15_q, w_q;
  shab_word_t w_exp, w_sel;

  logic       mem_we;
  logic [3:0] mem_waddr;
  shab_word_t mem_wdata;

  shab_word_t big0, big1, choose, major, t1;

  // Window entries t-16, t-15 first, then t-7, t-2 (all mod 16).
  always_comb begin
    case (phase_q)
      PH_RD_LO: begin
        rd_a_addr = rnd_q[3:0];
        rd_b_addr = 4'(rnd_q[3:0] + 4'd1);
      end
      PH_RD_HI: begin
        rd_a_addr = 4'(rnd_q[3:0] + 4'd9);
        rd_b_addr = 4'(rnd_q[3:0] + 4'd14);
      end
      default: begin
        rd_a_addr = rnd_q[3:0];
        rd_b_addr = rnd_q[3:0];
      end
    endcase
  end

  assign w_exp = w16_q
               + (ror(w15_q, 7) ^ ror(w15_q, 18) ^ (w15_q >> 3))
               + rd_a_q
               + (ror(rd_b_q, 17) ^ ror(rd_b_q, 19) ^ (rd_b_q >> 10));
  assign w_sel = (rnd_q[5:4] == 2'd0) ? w16_q : w_exp;

  // Expanded word replaces entry t-16 in place; writer owns the port while idle.
  always_comb begin
    if (busy_q) begin
      mem_we    = (phase_q == PH_EXP) && (rnd_q[5:4] != 2'd0);
      mem_waddr = rnd_q[3:0];
      mem_wdata = w_exp;
    end else begin
      mem_we    = wr_i.en;
      mem_waddr = wr_i.addr;
      mem_wdata = wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[rd_b_addr];
  end

  always_comb begin
    big1   = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
    choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1     = v_q[7] + big1 + choose + round_k(rnd_q) + w_q;
    big0   = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
    major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    v_next = {t1 + big0 + major, v_q[0], v_q[1], v_q[2],
              v_q[3] + t1, v_q[4], v_q[5], v_q[6]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      rnd_q   <= 6'd0;
      phase_q <= PH_RD_LO;
    end else begin
      done_q <= busy_q && (phase_q == PH_RND) && (&rnd_q);
      if (!busy_q) begin
        if (start_i) begin
          busy_q  <= 1'b1;
          rnd_q   <= 6'd0;
          phase_q <= PH_RD_LO;
        end
      end else begin
        phase_q <= 2'(phase_q + 2'd1);
        if (phase_q == PH_RND) begin
          rnd_q <= 6'(rnd_q + 6'd1);
          if (&rnd_q) begin
            busy_q <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      v_q <= hash_i;
    end else if (busy_q && (phase_q == PH_RND)) begin
      v_q <= v_next;
    end
    if (phase_q == PH_RD_HI) begin
      w16_q <= rd_a_q;
      w15_q <= rd_b_q;
    end
    if (phase_q == PH_EXP) begin
      w_q <= w_sel;
    end
  end

  // Feed-forward add of the chaining value.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hash_o[i] = hash_i[i] + v_q[i];
    end
  end

  assign done_o = done_q;

endmodule

// ----- sv/sha256_byte_stream_hasher_core.sv -----
// Top level of the SHA-256 byte-stream hasher: byte packing, padding, digest output.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | input     | in_valid_i / in_ready_o | data_byte_i, byte_valid_i, end_of_message_i
//  out     | output    | out_valid_o/out_ready_i | digest_word_o, word_index_o, last_word_o
//
// Flow: the 64th byte of a block starts the compression unit, which steps through two memory
// read phases, an expand phase and a round phase for each of its 64 rounds; no byte is taken
// until it finishes. An end of message adds padding writes and one or two compressions, then
// eight digest transactions.
// Reset clears control state and loads the initial hash value; block memory content is
// undefined until written. A stalled digest word holds until out_ready_i is high.
module sha256_byte_stream_hasher_core import shab_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;  // take byte transactions
  localparam logic [2:0] S_CMP  = 3'd1;  // wait for the compression unit
  localparam logic [2:0] S_PADW = 3'd2;  // write the word that carries the 0x80 marker
  localparam logic [2:0] S_ZERO = 3'd3;  // zero-fill the rest of the block
  localparam logic [2:0] S_LEN0 = 3'd4;  // write the upper length word
  localparam logic [2:0] S_LEN1 = 3'd5;  // write the lower length word, start last block
  localparam logic [2:0] S_OUT  = 3'd6;  // present the eight digest words

  logic [2:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;     // bytes held in the current block
  logic [63:0] len_q, len_d;       // message length in bits, wraps mod 2^64
  logic [31:0] acc_q, acc_d;       // partial word being packed, big-endian lanes
  logic [4:0]  wptr_q, wptr_d;     // zero-fill word pointer, may reach 16
  logic [2:0]  idx_q, idx_d;       // digest word index
  logic        end_q, end_d;       // message end pending behind a full block
  logic        two_q, two_d;       // padding spills into a second block
  logic        fin_q, fin_d;       // compression running on the final block
  shab_hash_t  hash_q, hash_d;

  logic        in_fire, out_fire;
  logic [31:0] acc_new, pad_word;
  logic [4:0]  zero_limit;
  shab_wr_t    wr;
  logic        cmp_start, cmp_done;
  shab_hash_t  cmp_hash;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  assign digest_word_o = hash_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = &idx_q;

  // Drop the incoming byte into its lane.
  always_comb begin
    acc_new = acc_q;
    case (fill_q[1:0])
      2'd0:    acc_new[31:24] = data_byte_i;
      2'd1:    acc_new[23:16] = data_byte_i;
      2'd2:    acc_new[15:8]  = data_byte_i;
      default: acc_new[7:0]   = data_byte_i;
    endcase
  end

  // Keep the bytes already packed, add the marker, clear the lanes after it.
  always_comb begin
    case (fill_q[1:0])
      2'd0:    pad_word = {PadByte, 24'h0};
      2'd1:    pad_word = {acc_q[31:24], PadByte, 16'h0};
      2'd2:    pad_word = {acc_q[31:16], PadByte, 8'h0};
      default: pad_word = {acc_q[31:8], PadByte};
    endcase
  end

  // A spilled pad block is zeroed to the end; the last block stops before the length.
  assign zero_limit = two_q ? 5'd16 : {1'b0, LenHiAddr};

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    len_d     = len_q;
    acc_d     = acc_q;
    wptr_d    = wptr_q;
    idx_d     = idx_q;
    end_d     = end_q;
    two_d     = two_q;
    fin_d     = fin_q;
    hash_d    = hash_q;
    wr        = '0;
    cmp_start = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          end_d = end_of_message_i;
          if (byte_valid_i) begin
            acc_d  = acc_new;
            fill_d = 6'(fill_q + 6'd1);
            len_d  = 64'(len_q + 64'd8);
            if (fill_q[1:0] == 2'd3) begin
              wr.en   = 1'b1;
              wr.addr = fill_q[5:2];
              wr.data = acc_new;
            end
          end
          // A full block goes through compression before any padding.
          if (byte_valid_i && (&fill_q)) begin
            cmp_start = 1'b1;
            state_d   = S_CMP;
          end else if (end_of_message_i) begin
            state_d = S_PADW;
          end
        end
      end
      S_CMP: begin
        if (cmp_done) begin
          hash_d = cmp_hash;
          if (fin_q) begin
            idx_d   = 3'd0;
            state_d = S_OUT;
          end else if (two_q) begin
            two_d   = 1'b0;
            wptr_d  = 5'd0;
            state_d = S_ZERO;
          end else if (end_q) begin
            state_d = S_PADW;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_PADW: begin
        wr.en   = 1'b1;
        wr.addr = fill_q[5:2];
        wr.data = pad_word;
        wptr_d  = 5'({1'b0, fill_q[5:2]} + 5'd1);
        // Marker at byte 56 or later leaves no room for the length.
        two_d   = &fill_q[5:3];
        state_d = S_ZERO;
      end
      S_ZERO: begin
        if (wptr_q == zero_limit) begin
          if (two_q) begin
            cmp_start = 1'b1;
            state_d   = S_CMP;
          end else begin
            state_d = S_LEN0;
          end
        end else begin
          wr.en   = 1'b1;
          wr.addr = wptr_q[3:0];
          wr.data = 32'h0;
          wptr_d  = 5'(wptr_q + 5'd1);
        end
      end
      S_LEN0: begin
        wr.en   = 1'b1;
        wr.addr = LenHiAddr;
        wr.data = len_q[63:32];
        state_d = S_LEN1;
      end
      S_LEN1: begin
        wr.en     = 1'b1;
        wr.addr   = LenLoAddr;
        wr.data   = len_q[31:0];
        fin_d     = 1'b1;
        cmp_start = 1'b1;
        state_d   = S_CMP;
      end
      S_OUT: begin
        if (out_fire) begin
          idx_d = 3'(idx_q + 3'd1);
          if (&idx_q) begin
            // Digest fully delivered: rearm for the next message.
            hash_d  = ShabIv;
            fill_d  = 6'd0;
            len_d   = 64'd0;
            end_d   = 1'b0;
            fin_d   = 1'b0;
            two_d   = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= 6'd0;
      len_q   <= 64'd0;
      wptr_q  <= 5'd0;
      idx_q   <= 3'd0;
      end_q   <= 1'b0;
      two_q   <= 1'b0;
      fin_q   <= 1'b0;
      hash_q  <= ShabIv;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      wptr_q  <= wptr_d;
      idx_q   <= idx_d;
      end_q   <= end_d;
      two_q   <= two_d;
      fin_q   <= fin_d;
      hash_q  <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  shab_compress u_compress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .start_i (cmp_start),
    .hash_i  (hash_q),
    .done_o  (cmp_done),
    .hash_o  (cmp_hash)
  );

`ifndef SYNTHESIS
  a_in_out_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output channels open at once");

  a_done_in_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_done |-> (state_q == S_CMP))
    else $error("compression finished outside the wait state");

  a_no_wr_in_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> !wr.en)
    else $error("block memory written while compressing");

  a_wptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ZERO) |-> (wptr_q <= 5'd16))
    else $error("zero-fill pointer beyond the block");

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_word_o) |=> (in_ready_o && (fill_q == 6'd0)))
    else $error("not rearmed after the last digest word");
`endif

endmodule
